// ===== rtl/cts_pkg.sv =====
package cts_pkg;

  localparam int unsigned ID_BITS_DEF = 8;

  localparam logic [6:0] RESET_TIMER_MAX = 7'd100;

  // event kinds
  localparam logic [2:0] KIND_VBLANK     = 3'd0;
  localparam logic [2:0] KIND_PROC_DONE  = 3'd1;
  localparam logic [2:0] KIND_DP_DONE    = 3'd2;
  localparam logic [2:0] KIND_START_GFX  = 3'd3;
  localparam logic [2:0] KIND_QUEUE_TASK = 3'd4;
  localparam logic [2:0] KIND_SUBMIT     = 3'd5;
  localparam logic [2:0] KIND_NMI        = 3'd6;

  // task class on the queue command
  localparam logic [1:0] CLASS_DISPLAY = 2'd1;
  localparam logic [1:0] CLASS_AUDIO   = 2'd2;

  // running class, also used as the start class code
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_AUDIO   = 2'd1;
  localparam logic [1:0] ACT_DISPLAY = 2'd2;

  // display task phase
  localparam logic [2:0] PH_NOT_STARTED = 3'd0;
  localparam logic [2:0] PH_RUNNING     = 3'd1;
  localparam logic [2:0] PH_INTERRUPTED = 3'd2;
  localparam logic [2:0] PH_FINISHED    = 3'd3;
  localparam logic [2:0] PH_FINISHED_DP = 3'd4;

  // register map
  localparam logic REG_AUDIO_ENABLE = 1'b0;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] task_class;
    logic [7:0] task_id;
    logic       wants_notify;
    logic       yielded;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  start_class;
    logic [7:0]  start_id;
    logic        yield_request;
    logic        fake_complete;
    logic        audio_done;
    logic [7:0]  audio_done_id;
    logic        display_done;
    logic [7:0]  display_done_id;
    logic [1:0]  active_class;
    logic [31:0] vblank_count;
    logic [6:0]  reset_timer;
  } out_item_t;

endpackage

// ===== rtl/cts_in_if.sv =====
interface cts_in_if;
  import cts_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/cts_out_if.sv =====
interface cts_out_if;
  import cts_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/cts_cfg_regs.sv =====
module cts_cfg_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        audio_enable_o
);
  import cts_pkg::*;

  logic audio_enable_q;
  logic audio_enable_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_AUDIO_ENABLE);

  always_comb begin
    audio_enable_d = audio_enable_q;
    if (wr_en) begin
      audio_enable_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      audio_enable_q <= 1'b1;
    end else begin
      audio_enable_q <= audio_enable_d;
    end
  end

  assign prdata = (paddr[2] == REG_AUDIO_ENABLE) ? {31'd0, audio_enable_q} : 32'd0;
  assign audio_enable_o = audio_enable_q;

endmodule

// ===== rtl/cts_core.sv =====
module cts_core #(
  parameter int unsigned ID_BITS = cts_pkg::ID_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  cts_pkg::in_item_t  item_i,
  input  logic               audio_enable_i,
  output cts_pkg::out_item_t res_o
);
  import cts_pkg::*;

  localparam int unsigned IdWide = ID_BITS + 8;

  typedef struct packed {
    logic               valid;
    logic               notify;
    logic [ID_BITS-1:0] id;
  } slot_t;

  function automatic logic [7:0] id_out(input logic [ID_BITS-1:0] v);
    logic [IdWide-1:0] w;
    w = IdWide'(v);
    return w[7:0];
  endfunction

  slot_t       a_cur_q, a_cur_d, a_nxt_q, a_nxt_d;
  slot_t       d_cur_q, d_cur_d, d_nxt_q, d_nxt_d;
  logic [2:0]  phase_q, phase_d;
  logic [1:0]  active_q, active_d;
  logic [31:0] vblanks_q, vblanks_d;
  logic [6:0]  rtimer_q, rtimer_d;

  logic [IdWide-1:0] tid_wide;
  slot_t             tslot;
  logic              go_audio;
  logic              go_disp;
  out_item_t         res;

  assign tid_wide     = IdWide'(item_i.task_id);
  assign tslot.valid  = 1'b1;
  assign tslot.notify = item_i.wants_notify;
  assign tslot.id     = tid_wide[ID_BITS-1:0];

  always_comb begin
    a_cur_d   = a_cur_q;
    a_nxt_d   = a_nxt_q;
    d_cur_d   = d_cur_q;
    d_nxt_d   = d_nxt_q;
    phase_d   = phase_q;
    active_d  = active_q;
    vblanks_d = vblanks_q;
    rtimer_d  = rtimer_q;
    go_audio  = 1'b0;
    go_disp   = 1'b0;
    res       = '0;

    if (step_i) begin
      unique case (item_i.kind)
        KIND_VBLANK: begin
          vblanks_d = vblanks_q + 32'd1;
          if (rtimer_q != 7'd0 && rtimer_q < RESET_TIMER_MAX) begin
            rtimer_d = rtimer_q + 7'd1;
          end
          if (!a_cur_q.valid && a_nxt_q.valid) begin
            a_cur_d       = a_nxt_q;
            a_nxt_d.valid = 1'b0;
          end
          if (!d_cur_q.valid && d_nxt_q.valid) begin
            d_cur_d       = d_nxt_q;
            phase_d       = PH_NOT_STARTED;
            d_nxt_d.valid = 1'b0;
          end
          if (a_cur_d.valid) begin
            if (active_q == ACT_NONE) begin
              go_audio = 1'b1;
            end else if (active_q == ACT_DISPLAY) begin
              if (d_cur_d.valid) begin
                phase_d = PH_INTERRUPTED;
              end
              res.yield_request = 1'b1;
            end
          end else if (active_q == ACT_NONE && d_cur_d.valid && phase_d != PH_FINISHED) begin
            go_disp = 1'b1;
          end
        end
        KIND_PROC_DONE: begin
          if (active_q != ACT_NONE) begin
            active_d = ACT_NONE;
            if (active_q == ACT_DISPLAY && d_cur_q.valid && phase_q == PH_INTERRUPTED) begin
              if (!item_i.yielded) begin
                phase_d = PH_FINISHED;
              end
              go_audio = a_cur_q.valid;
            end else if (active_q == ACT_AUDIO) begin
              go_disp = d_cur_q.valid && phase_q != PH_FINISHED;
              if (a_cur_q.valid && a_cur_q.notify) begin
                res.audio_done    = 1'b1;
                res.audio_done_id = id_out(a_cur_q.id);
              end
              a_cur_d.valid = 1'b0;
            end else if (d_cur_q.valid) begin
              phase_d = PH_FINISHED;
            end
          end
        end
        KIND_DP_DONE: begin
          if (d_cur_q.valid) begin
            if (d_cur_q.notify) begin
              res.display_done    = 1'b1;
              res.display_done_id = id_out(d_cur_q.id);
            end
            phase_d       = PH_FINISHED_DP;
            d_cur_d.valid = 1'b0;
          end
        end
        KIND_START_GFX: begin
          go_disp = active_q == ACT_NONE && d_cur_q.valid && phase_q == PH_NOT_STARTED;
        end
        KIND_QUEUE_TASK: begin
          if (item_i.task_class == CLASS_AUDIO) begin
            a_nxt_d = tslot;
          end else if (item_i.task_class == CLASS_DISPLAY) begin
            d_nxt_d = tslot;
          end
        end
        KIND_SUBMIT: begin
          if (!d_cur_q.valid) begin
            d_cur_d       = tslot;
            phase_d       = PH_NOT_STARTED;
            d_nxt_d.valid = 1'b0;
            go_disp       = active_q == ACT_NONE;
          end else begin
            d_nxt_d = tslot;
          end
        end
        KIND_NMI: begin
          rtimer_d = 7'd1;
        end
        default: begin
        end
      endcase

      // audio start: when disabled the completion is faked by the environment
      if (go_audio) begin
        active_d = ACT_AUDIO;
        if (audio_enable_i) begin
          res.start_class = ACT_AUDIO;
          res.start_id    = id_out(a_cur_d.id);
        end else begin
          res.fake_complete = 1'b1;
        end
      end
      if (go_disp) begin
        active_d        = ACT_DISPLAY;
        phase_d         = PH_RUNNING;
        res.start_class = ACT_DISPLAY;
        res.start_id    = id_out(d_cur_d.id);
      end
    end

    res.active_class = active_d;
    res.vblank_count = vblanks_d;
    res.reset_timer  = rtimer_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_cur_q   <= '0;
      a_nxt_q   <= '0;
      d_cur_q   <= '0;
      d_nxt_q   <= '0;
      phase_q   <= PH_NOT_STARTED;
      active_q  <= ACT_NONE;
      vblanks_q <= 32'd0;
      rtimer_q  <= 7'd0;
    end else begin
      a_cur_q   <= a_cur_d;
      a_nxt_q   <= a_nxt_d;
      d_cur_q   <= d_cur_d;
      d_nxt_q   <= d_nxt_d;
      phase_q   <= phase_d;
      active_q  <= active_d;
      vblanks_q <= vblanks_d;
      rtimer_q  <= rtimer_d;
    end
  end

  assign res_o = res;

endmodule

// ===== rtl/coprocessor_task_scheduler_unit.sv =====
// Event-driven scheduler for one coprocessor shared by audio and display tasks.
// Each beat on evt_i is one event (vblank, processor complete, display-processor
// complete, start gfx, queue task, direct display submit, nmi) and yields exactly
// one beat on res_o with the task started, yield and completion notifications,
// the running class, the vblank count and the reset timer after that event.
// One event can be taken every cycle while res_o takes each result: an accepted
// event is held in an input register, decided and applied to the scheduler
// state once the output register is free, and its result registered in the
// output register, from which res_o offers it. While a result waits for
// res_o.ready the input register still takes one more event; after that
// evt_i.ready stays low until the waiting result leaves. The audio_enable
// register (byte address 0, reset 1) is written over the APB port, by the user
// only while no event is in flight; the block itself does not enforce this.
module coprocessor_task_scheduler_unit #(
  parameter int unsigned ID_BITS = cts_pkg::ID_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cts_in_if.sink      evt_i,
  cts_out_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cts_pkg::*;

  logic      audio_enable;
  logic      in_valid_q, in_valid_d;
  in_item_t  in_item_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;
  out_item_t res;
  logic      out_free;
  logic      step;

  cts_cfg_regs u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .audio_enable_o (audio_enable)
  );

  assign out_free    = !out_valid_q || res_o.ready;
  assign step        = in_valid_q && out_free;
  assign evt_i.ready = !in_valid_q || out_free;

  cts_core #(
    .ID_BITS (ID_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .item_i         (in_item_q),
    .audio_enable_i (audio_enable),
    .res_o          (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (evt_i.ready) begin
      in_valid_d = evt_i.valid;
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload beats, no reset
  always_ff @(posedge clk_i) begin
    if (evt_i.ready && evt_i.valid) begin
      in_item_q <= evt_i.item;
    end
    if (step) begin
      out_item_q <= res;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.item  = out_item_q;

endmodule
